### rtl/core/arst_pkg.sv
// ----------------------------------------------------------------------------
// arst_pkg
// Shared types and constants of the acceptance rate step tuner: the input and
// result words, the queue entry passed from front to back, and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package arst_pkg;

  localparam int MAX_TYPES   = 16;
  localparam int TYPE_W      = 4;
  localparam int VALUE_W     = 32;
  localparam int CNT_W       = 16;
  localparam int RATIO_W     = 16;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 14;
  localparam int VALUE_FRAC  = 16;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int PERIOD_W    = 16;
  localparam int ACTIVE_W    = 5;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_TUNE_PERIOD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TYPES = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_STEPS   = RATIO_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // Widths of the rescaling datapath.
  localparam int PROD_W      = GAIN_W + RATIO_W + 1;
  localparam int PSH_W       = PROD_W - GAIN_FRAC;
  localparam int FACT_W      = PSH_W + 1;
  localparam int SCL_W       = VALUE_W + FACT_W;
  localparam int NV_W        = SCL_W - VALUE_FRAC;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_COUNT = 1'b1
  } op_kind_t;

  typedef struct packed {
    logic                      req_type;
    logic [TYPE_W-1:0]         type_index;
    logic signed [VALUE_W-1:0] start_value;
    logic                      rejected_early;
    logic                      trial_taken;
    logic                      tune_enabled;
    logic                      bounded;
    logic [GAIN_W-1:0]         gain;
    logic [RATIO_W-1:0]        target_ratio;
    logic signed [VALUE_W-1:0] value_min;
    logic signed [VALUE_W-1:0] value_max;
  } in_word_t;

  typedef struct packed {
    logic [TYPE_W-1:0]         type_out;
    logic signed [VALUE_W-1:0] step_value;
    logic                      period_done;
  } out_word_t;

  typedef struct packed {
    op_kind_t                  op;
    logic [TYPE_W-1:0]         type_index;
    logic signed [VALUE_W-1:0] start_value;
    logic                      trial_taken;
    logic                      tune_enabled;
    logic                      bounded;
    logic [GAIN_W-1:0]         gain;
    logic [RATIO_W-1:0]        target_ratio;
    logic signed [VALUE_W-1:0] value_min;
    logic signed [VALUE_W-1:0] value_max;
  } q_entry_t;

endpackage

`default_nettype wire

### rtl/core/arst_queue.sv
// ----------------------------------------------------------------------------
// arst_queue
// Short first-in first-out queue of classified operations between the front
// and the back of the step tuner.
// ----------------------------------------------------------------------------
`default_nettype none

module arst_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire arst_pkg::q_entry_t push_data,
  output      logic               full,
  input  wire logic               pop,
  output      logic               head_valid,
  output      arst_pkg::q_entry_t head
);
  import arst_pkg::*;

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/core/arst_front.sv
// ----------------------------------------------------------------------------
// arst_front
// Holds the configuration registers, accepts input words and classifies them:
// loads and counted outcomes go to the queue, ignored outcomes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module arst_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output      logic                                busy,
  input  wire arst_pkg::in_word_t                  in_word,
  input  wire logic                                cfg_we,
  input  wire logic [arst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [arst_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                                q_full,
  output      logic                                q_push,
  output      arst_pkg::q_entry_t                  q_data,
  output      logic [arst_pkg::PERIOD_W-1:0]       tune_period
);
  import arst_pkg::*;

  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [ACTIVE_W-1:0] active_r, active_nxt;
  logic                accept;
  logic                keep;

  assign busy        = q_full;
  assign accept      = start && !q_full;
  assign tune_period = period_r;

  // A load always goes through; an outcome only for a tracked type that
  // was not rejected early.
  always_comb begin
    if (in_word.req_type == OP_LOAD) begin
      keep = 1'b1;
    end else begin
      keep = ({1'b0, in_word.type_index} < active_r) && !in_word.rejected_early;
    end
    q_push              = accept && keep;
    q_data.op           = op_kind_t'(in_word.req_type);
    q_data.type_index   = in_word.type_index;
    q_data.start_value  = in_word.start_value;
    q_data.trial_taken  = in_word.trial_taken;
    q_data.tune_enabled = in_word.tune_enabled;
    q_data.bounded      = in_word.bounded;
    q_data.gain         = in_word.gain;
    q_data.target_ratio = in_word.target_ratio;
    q_data.value_min    = in_word.value_min;
    q_data.value_max    = in_word.value_max;
  end

  always_comb begin
    period_nxt = period_r;
    active_nxt = active_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TUNE_PERIOD:  period_nxt = cfg_wdata[PERIOD_W-1:0];
        CFG_ACTIVE_TYPES: active_nxt = cfg_wdata[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      active_r <= ACTIVE_RESET;
    end else begin
      period_r <= period_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/arst_back.sv
// ----------------------------------------------------------------------------
// arst_back
// Executes queued operations: loads, counter updates and, when a tuning
// period closes, the ratio division and the rescaling of the step value.
// ----------------------------------------------------------------------------
`default_nettype none

module arst_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  input  wire arst_pkg::q_entry_t             q_head,
  output      logic                           q_pop,
  input  wire logic [arst_pkg::PERIOD_W-1:0]  tune_period,
  output      logic                           out_valid,
  output      arst_pkg::out_word_t            out_word
);
  import arst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_GAIN,
    S_FACT,
    S_SCALE,
    S_WRITE
  } state_t;

  state_t                     state_r, state_nxt;
  logic signed [VALUE_W-1:0]  step_r [MAX_TYPES];
  logic signed [VALUE_W-1:0]  step_nxt [MAX_TYPES];
  logic [CNT_W-1:0]           att_r [MAX_TYPES];
  logic [CNT_W-1:0]           att_nxt [MAX_TYPES];
  logic [CNT_W-1:0]           acc_r [MAX_TYPES];
  logic [CNT_W-1:0]           acc_nxt [MAX_TYPES];

  q_entry_t                   cur_r, cur_nxt;
  logic [RATIO_W-1:0]         rem_r, rem_nxt;
  logic [RATIO_W-1:0]         quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                       sat_r, sat_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [FACT_W-1:0]   fact_r, fact_nxt;
  logic signed [SCL_W-1:0]    scl_r, scl_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_word_t                  out_word_r, out_word_nxt;

  logic [PERIOD_W-1:0]        period_eff;
  logic [CNT_W-1:0]           att_inc;
  logic [CNT_W-1:0]           acc_inc;
  logic [RATIO_W:0]           rem_sh;
  logic [RATIO_W-1:0]         ratio;
  logic signed [RATIO_W:0]    diff;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [PSH_W-1:0]    prod_sh;
  logic signed [SCL_W-1:0]    scl_rnd;
  logic signed [NV_W-1:0]     nv;
  logic signed [VALUE_W-1:0]  new_val;

  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;
  // A zero period behaves as a period of one.
  assign period_eff = (tune_period == '0) ? PERIOD_W'(1) : tune_period;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    att_nxt       = att_r;
    acc_nxt       = acc_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    sat_nxt       = sat_r;
    prod_nxt      = prod_r;
    fact_nxt      = fact_r;
    scl_nxt       = scl_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    q_pop         = 1'b0;
    att_inc       = att_r[q_head.type_index] + 1'b1;
    acc_inc       = acc_r[q_head.type_index] + CNT_W'(q_head.trial_taken);
    rem_sh        = {rem_r, 1'b0};
    ratio         = sat_r ? '1 : quo_r;
    diff          = $signed({1'b0, ratio}) - $signed({1'b0, cur_r.target_ratio});
    prod_rnd      = prod_r + PROD_W'(1 << (GAIN_FRAC - 1));
    prod_sh       = PSH_W'(prod_rnd >>> GAIN_FRAC);
    scl_rnd       = scl_r + SCL_W'(1 << (VALUE_FRAC - 1));
    nv            = NV_W'(scl_rnd >>> VALUE_FRAC);
    new_val       = step_r[cur_r.type_index];

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_head.op)
            OP_LOAD: begin
              step_nxt[q_head.type_index] = q_head.start_value;
            end
            OP_COUNT: begin
              att_nxt[q_head.type_index] = att_inc;
              acc_nxt[q_head.type_index] = acc_inc;
              if (q_head.tune_enabled) begin
                if (att_inc == period_eff) begin
                  // Period closed: counters clear now, the value follows
                  // once the rescale is through.
                  att_nxt[q_head.type_index] = '0;
                  acc_nxt[q_head.type_index] = '0;
                  cur_nxt   = q_head;
                  sat_nxt   = (acc_inc >= att_inc);
                  rem_nxt   = (acc_inc >= att_inc) ? '0 : acc_inc;
                  quo_nxt   = '0;
                  cnt_nxt   = DIV_CNT_W'(DIV_STEPS - 1);
                  state_nxt = S_DIV;
                end else begin
                  out_valid_nxt            = 1'b1;
                  out_word_nxt.type_out    = q_head.type_index;
                  out_word_nxt.step_value  = step_r[q_head.type_index];
                  out_word_nxt.period_done = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        // One quotient bit per cycle; the divisor equals the period.
        if (rem_sh >= {1'b0, period_eff}) begin
          rem_nxt = RATIO_W'(rem_sh - {1'b0, period_eff});
          quo_nxt = {quo_r[RATIO_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[RATIO_W-1:0];
          quo_nxt = {quo_r[RATIO_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_GAIN;
        end
      end
      S_GAIN: begin
        prod_nxt  = PROD_W'($signed({1'b0, cur_r.gain})) * PROD_W'(diff);
        state_nxt = S_FACT;
      end
      S_FACT: begin
        fact_nxt  = FACT_W'(prod_sh) + FACT_W'(1 << VALUE_FRAC);
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        scl_nxt   = SCL_W'(step_r[cur_r.type_index]) * SCL_W'(fact_r);
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (cur_r.bounded) begin
          if (nv >= NV_W'(cur_r.value_min) && nv <= NV_W'(cur_r.value_max)) begin
            new_val = VALUE_W'(nv);
          end
        end else if (nv > $signed(NV_W'({1'b0, {(VALUE_W-1){1'b1}}}))) begin
          new_val = {1'b0, {(VALUE_W-1){1'b1}}};
        end else if (nv < NV_W'($signed({1'b1, {(VALUE_W-1){1'b0}}}))) begin
          new_val = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
          new_val = VALUE_W'(nv);
        end
        step_nxt[cur_r.type_index] = new_val;
        out_valid_nxt            = 1'b1;
        out_word_nxt.type_out    = cur_r.type_index;
        out_word_nxt.step_value  = new_val;
        out_word_nxt.period_done = 1'b1;
        state_nxt                = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_TYPES; i++) begin
        step_r[i] <= '0;
        att_r[i]  <= '0;
        acc_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      att_r       <= att_nxt;
      acc_r       <= acc_nxt;
    end
    cur_r      <= cur_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    sat_r      <= sat_nxt;
    prod_r     <= prod_nxt;
    fact_r     <= fact_nxt;
    scl_r      <= scl_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/acceptance_rate_step_tuner_unit.sv
// ----------------------------------------------------------------------------
// acceptance_rate_step_tuner_unit
// Per move type step tuning from the observed acceptance ratio: counts trial
// outcomes and rescales the step value at the end of every tuning period.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Handshake
//   -------   -----------------------------  ---------------------------------
//   input     start, busy, in_word           word taken when start && !busy
//   result    out_valid, out_word            one-cycle strobe, never stalled
//   config    cfg_we, cfg_index, cfg_wdata   register written when cfg_we
//
// Flow: a load or an ordinary outcome word is written into the queue and
// then taken by the back end, so words stream at one per cycle while the
// back end is idle. Only an outcome with tuning enabled gives a result; a
// load gives none. An outcome that closes a tuning period holds the back
// end while it takes the word from the queue, runs the bit-per-cycle ratio
// divider, then the gain multiply, the factor rounding, the value multiply
// and the final rounding with bounding or saturation.
// Reset clears all step values and counters at once (flip-flops) and loads
// the configuration defaults; no clearing pass is needed.
// busy rises only when the two-entry queue is full, which happens while the
// back end works through a period close. The result side has no back-pressure.
//
// ----------------------------------------------------------------------------
`default_nettype none

module acceptance_rate_step_tuner_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output      logic                               busy,
  input  wire arst_pkg::in_word_t                 in_word,
  output      logic                               out_valid,
  output      arst_pkg::out_word_t                out_word,
  input  wire logic                               cfg_we,
  input  wire logic [arst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [arst_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import arst_pkg::*;

  // Front to queue.
  logic                q_push;
  q_entry_t            q_wdata;
  logic                q_full;
  // Queue to back.
  logic                q_valid;
  q_entry_t            q_head;
  logic                q_pop;
  logic [PERIOD_W-1:0] tune_period;

  // The front end owns the configuration registers and drops outcome words
  // that the block ignores (untracked type, early rejection), so only work
  // that touches state reaches the queue.
  arst_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata),
    .tune_period (tune_period)
  );

  // The queue lets the front keep accepting words while the back end is
  // busy with a period close.
  arst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // The back end holds the per-type state and the rescaling datapath, and
  // drives the registered result word.
  arst_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .tune_period (tune_period),
    .out_valid   (out_valid),
    .out_word    (out_word)
  );

endmodule

`default_nettype wire
